### hw/rtl/xxh_pkg.sv
// ----------------------------------------------------------------------------
// XXH64 shared definitions
// Primes, sequencer states and the structs passed between the hash engine,
// its shared multiplier and the top level.
// ----------------------------------------------------------------------------
package xxh_pkg;

    // XXH64 primes
    localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
    localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

    // Lane start offsets relative to the seed
    localparam logic [63:0] LANE0_OFS = PRIME1 + PRIME2;
    localparam logic [63:0] LANE3_OFS = 64'd0 - PRIME1;

    // Sequencer states of the hash engine
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RND_A,
        ST_RND_B,
        ST_FINAL,
        ST_SUM,
        ST_MRG_H,
        ST_ADDLEN,
        ST_FOLD_CHK,
        ST_FOLD_H,
        ST_CHUNK_A,
        ST_CHUNK_B,
        ST_BYTE_CHK,
        ST_BYTE_A,
        ST_BYTE_B,
        ST_AV1,
        ST_AV2,
        ST_EMIT
    } state_t;

    // What a lane round is being used for
    typedef enum logic [1:0] {
        MODE_STRIPE,
        MODE_MERGE,
        MODE_FOLD
    } mode_t;

    // Request to the shared 64-bit multiplier
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    // Status and product from the shared 64-bit multiplier
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] p;
    } mul_rsp_t;

    // Finished digest from the engine
    typedef struct packed {
        logic        valid;
        logic [63:0] digest;
    } res_t;

endpackage

### hw/rtl/xxh_mul64.sv
// ----------------------------------------------------------------------------
// XXH64 shared multiplier
// Low 64 bits of a 64x64 product, built from three 32x32 partial products
// on a single 32x32 multiplier.
// ----------------------------------------------------------------------------
module xxh_mul64 (
    input  logic              clk,
    input  logic              rst_n,
    input  xxh_pkg::mul_req_t req,
    output xxh_pkg::mul_rsp_t rsp
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] prod_next;

    // Operand selection: lo*lo, then lo*hi, then hi*lo
    always_comb
    begin
        op_x = (step_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
        op_y = (step_reg == 2'd1) ? b_reg[63:32] : b_reg[31:0];
        prod_next = {32'd0, op_x} * {32'd0, op_y};
    end

    // Accumulate the registered partial product of the previous step
    always_comb
    begin
        case (step_reg)
            2'd1:    acc_next = prod_reg;
            2'd2:    acc_next = acc_reg + {prod_reg[31:0], 32'd0};
            2'd3:    acc_next = acc_reg + {prod_reg[31:0], 32'd0};
            default: acc_next = acc_reg;
        endcase
    end

    // Control: start loads operands, four busy steps, then a done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 2'd3);
            if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
            else if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
        end
    end

    // Operand and product registers
    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        if (busy_reg)
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

endmodule

### hw/rtl/xxh_engine.sv
// ----------------------------------------------------------------------------
// XXH64 hash engine
// Lane accumulators, stripe buffer and the sequencer that drives every
// multiply of the lane rounds, merge, tail folds and avalanche through one
// shared multiplier.
// ----------------------------------------------------------------------------
module xxh_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [63:0]    in_word,
    input  logic [3:0]     in_count,
    input  logic           in_last,
    input  logic           cfg_we,
    input  logic [63:0]    cfg_wdata,
    input  logic           res_free,
    output xxh_pkg::res_t  res
);

    xxh_pkg::state_t state_reg;
    xxh_pkg::state_t state_next;
    xxh_pkg::mode_t  mode_reg;
    xxh_pkg::mode_t  mode_next;

    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic [1:0]  wp_reg;
    logic [1:0]  wp_next;
    logic [2:0]  k_reg;
    logic [2:0]  k_next;
    logic [2:0]  rem_reg;
    logic [2:0]  rem_next;
    logic        fin_reg;
    logic        fin_next;
    logic        tail_reg;
    logic        tail_next;
    logic [63:0] word_reg;
    logic [63:0] word_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic [63:0] h_reg;
    logic [63:0] h_next;
    logic [63:0] t_reg;
    logic [63:0] t_next;
    logic [63:0] total_reg;
    logic [63:0] total_next;
    logic [63:0] seed_reg;
    logic [63:0] seed_next;
    logic [63:0] acc_reg [4];
    logic [63:0] acc_next [4];
    logic [63:0] stripe_reg [3];

    logic              stripe_we;
    logic [3:0]        n_eff;
    logic [63:0]       acc_rd;
    logic [63:0]       stripe_rd;
    logic [63:0]       round_opnd;
    logic [63:0]       byte_shift;
    logic [63:0]       sum_term;
    logic              mul_state;
    logic              done;
    xxh_pkg::mul_req_t mul_req;
    xxh_pkg::mul_rsp_t mul_rsp;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [3:0] in_count_sat(input logic [3:0] c);
        return (c > 4'd8) ? 4'd8 : c;
    endfunction

    xxh_mul64 u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign done = mul_rsp.done;

    // Operand reads and small helpers
    always_comb
    begin
        n_eff  = (in_count_sat(cnt_reg));
        acc_rd = acc_reg[idx_reg];
        case (idx_reg)
            2'd0:    stripe_rd = stripe_reg[0];
            2'd1:    stripe_rd = stripe_reg[1];
            2'd2:    stripe_rd = stripe_reg[2];
            default: stripe_rd = word_reg;
        endcase
        case (mode_reg)
            xxh_pkg::MODE_STRIPE: round_opnd = stripe_rd;
            xxh_pkg::MODE_MERGE:  round_opnd = acc_rd;
            default:              round_opnd = (idx_reg < wp_reg) ? stripe_rd : word_reg;
        endcase
        byte_shift = word_reg >> {k_reg, 3'b000};
        case (idx_reg)
            2'd0:    sum_term = rotl(acc_rd, 1);
            2'd1:    sum_term = rotl(acc_rd, 7);
            2'd2:    sum_term = rotl(acc_rd, 12);
            default: sum_term = rotl(acc_rd, 18);
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            xxh_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = xxh_pkg::ST_DISPATCH;
                end
            end
            xxh_pkg::ST_DISPATCH:
            begin
                if (!fin_reg)
                begin
                    state_next = (wp_reg == 2'd3) ? xxh_pkg::ST_RND_A : xxh_pkg::ST_IDLE;
                end
                else if (n_eff == 4'd8 && wp_reg == 2'd3)
                begin
                    state_next = xxh_pkg::ST_RND_A;
                end
                else
                begin
                    state_next = xxh_pkg::ST_FINAL;
                end
            end
            xxh_pkg::ST_RND_A:
            begin
                if (done)
                begin
                    state_next = xxh_pkg::ST_RND_B;
                end
            end
            xxh_pkg::ST_RND_B:
            begin
                if (done)
                begin
                    case (mode_reg)
                        xxh_pkg::MODE_STRIPE:
                        begin
                            if (idx_reg == 2'd3)
                            begin
                                state_next = fin_reg ? xxh_pkg::ST_FINAL : xxh_pkg::ST_IDLE;
                            end
                            else
                            begin
                                state_next = xxh_pkg::ST_RND_A;
                            end
                        end
                        xxh_pkg::MODE_MERGE: state_next = xxh_pkg::ST_MRG_H;
                        default:             state_next = xxh_pkg::ST_FOLD_H;
                    endcase
                end
            end
            xxh_pkg::ST_FINAL:
            begin
                state_next = (|total_reg[63:5]) ? xxh_pkg::ST_SUM : xxh_pkg::ST_ADDLEN;
            end
            xxh_pkg::ST_SUM:
            begin
                if (idx_reg == 2'd3)
                begin
                    state_next = xxh_pkg::ST_RND_A;
                end
            end
            xxh_pkg::ST_MRG_H:
            begin
                if (done)
                begin
                    state_next = (idx_reg == 2'd3) ? xxh_pkg::ST_ADDLEN : xxh_pkg::ST_RND_A;
                end
            end
            xxh_pkg::ST_ADDLEN:
            begin
                state_next = xxh_pkg::ST_FOLD_CHK;
            end
            xxh_pkg::ST_FOLD_CHK:
            begin
                if (idx_reg < wp_reg || tail_reg)
                begin
                    state_next = xxh_pkg::ST_RND_A;
                end
                else
                begin
                    state_next = rem_reg[2] ? xxh_pkg::ST_CHUNK_A : xxh_pkg::ST_BYTE_CHK;
                end
            end
            xxh_pkg::ST_FOLD_H:
            begin
                if (done)
                begin
                    state_next = xxh_pkg::ST_FOLD_CHK;
                end
            end
            xxh_pkg::ST_CHUNK_A:
            begin
                if (done)
                begin
                    state_next = xxh_pkg::ST_CHUNK_B;
                end
            end
            xxh_pkg::ST_CHUNK_B:
            begin
                if (done)
                begin
                    state_next = xxh_pkg::ST_BYTE_CHK;
                end
            end
            xxh_pkg::ST_BYTE_CHK:
            begin
                state_next = (k_reg < rem_reg) ? xxh_pkg::ST_BYTE_A : xxh_pkg::ST_AV1;
            end
            xxh_pkg::ST_BYTE_A:
            begin
                if (done)
                begin
                    state_next = xxh_pkg::ST_BYTE_B;
                end
            end
            xxh_pkg::ST_BYTE_B:
            begin
                if (done)
                begin
                    state_next = xxh_pkg::ST_BYTE_CHK;
                end
            end
            xxh_pkg::ST_AV1:
            begin
                if (done)
                begin
                    state_next = xxh_pkg::ST_AV2;
                end
            end
            xxh_pkg::ST_AV2:
            begin
                if (done)
                begin
                    state_next = xxh_pkg::ST_EMIT;
                end
            end
            xxh_pkg::ST_EMIT:
            begin
                if (res_free)
                begin
                    state_next = xxh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = xxh_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: handshake, multiplier request and result
    always_comb
    begin
        in_ready  = (state_reg == xxh_pkg::ST_IDLE);
        mul_state = 1'b1;
        mul_req.a = h_reg;
        mul_req.b = xxh_pkg::PRIME1;
        case (state_reg)
            xxh_pkg::ST_RND_A:
            begin
                mul_req.a = round_opnd;
                mul_req.b = xxh_pkg::PRIME2;
            end
            xxh_pkg::ST_RND_B:   mul_req.a = rotl(t_reg, 31);
            xxh_pkg::ST_MRG_H:   mul_req.a = h_reg;
            xxh_pkg::ST_FOLD_H:  mul_req.a = rotl(h_reg, 27);
            xxh_pkg::ST_CHUNK_A: mul_req.a = {32'd0, word_reg[31:0]};
            xxh_pkg::ST_CHUNK_B:
            begin
                mul_req.a = rotl(h_reg, 23);
                mul_req.b = xxh_pkg::PRIME2;
            end
            xxh_pkg::ST_BYTE_A:
            begin
                mul_req.a = {56'd0, byte_shift[7:0]};
                mul_req.b = xxh_pkg::PRIME5;
            end
            xxh_pkg::ST_BYTE_B:  mul_req.a = rotl(h_reg, 11);
            xxh_pkg::ST_AV1:
            begin
                mul_req.a = h_reg ^ (h_reg >> 33);
                mul_req.b = xxh_pkg::PRIME2;
            end
            xxh_pkg::ST_AV2:
            begin
                mul_req.a = h_reg ^ (h_reg >> 29);
                mul_req.b = xxh_pkg::PRIME3;
            end
            default:             mul_state = 1'b0;
        endcase
        mul_req.start = mul_state && !mul_rsp.busy && !mul_rsp.done;
        res.valid     = (state_reg == xxh_pkg::ST_EMIT) && res_free;
        res.digest    = h_reg ^ (h_reg >> 32);
        stripe_we     = (state_reg == xxh_pkg::ST_DISPATCH) && !fin_reg && (wp_reg != 2'd3);
    end

    // Datapath next values
    always_comb
    begin
        mode_next  = mode_reg;
        idx_next   = idx_reg;
        wp_next    = wp_reg;
        k_next     = k_reg;
        rem_next   = rem_reg;
        fin_next   = fin_reg;
        tail_next  = tail_reg;
        word_next  = word_reg;
        cnt_next   = cnt_reg;
        h_next     = h_reg;
        t_next     = t_reg;
        total_next = total_reg;
        seed_next  = seed_reg;
        acc_next   = acc_reg;
        case (state_reg)
            xxh_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    word_next = in_word;
                    cnt_next  = in_count;
                    fin_next  = in_last;
                end
            end
            xxh_pkg::ST_DISPATCH:
            begin
                idx_next  = 2'd0;
                mode_next = xxh_pkg::MODE_STRIPE;
                if (!fin_reg)
                begin
                    total_next = total_reg + 64'd8;
                    if (wp_reg != 2'd3)
                    begin
                        wp_next = wp_reg + 2'd1;
                    end
                end
                else
                begin
                    total_next = total_reg + {60'd0, n_eff};
                    tail_next  = (n_eff == 4'd8) && (wp_reg != 2'd3);
                    rem_next   = n_eff[3] ? 3'd0 : n_eff[2:0];
                end
            end
            xxh_pkg::ST_RND_A:
            begin
                if (done)
                begin
                    t_next = ((mode_reg == xxh_pkg::MODE_STRIPE) ? acc_rd : 64'd0) + mul_rsp.p;
                end
            end
            xxh_pkg::ST_RND_B:
            begin
                if (done)
                begin
                    if (mode_reg == xxh_pkg::MODE_STRIPE)
                    begin
                        acc_next[idx_reg] = mul_rsp.p;
                        idx_next = idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            wp_next = 2'd0;
                        end
                    end
                    else
                    begin
                        h_next = h_reg ^ mul_rsp.p;
                    end
                end
            end
            xxh_pkg::ST_FINAL:
            begin
                idx_next = 2'd0;
                if (!(|total_reg[63:5]))
                begin
                    h_next = seed_reg + xxh_pkg::PRIME5;
                end
            end
            xxh_pkg::ST_SUM:
            begin
                h_next   = ((idx_reg == 2'd0) ? 64'd0 : h_reg) + sum_term;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    mode_next = xxh_pkg::MODE_MERGE;
                end
            end
            xxh_pkg::ST_MRG_H:
            begin
                if (done)
                begin
                    h_next   = mul_rsp.p + xxh_pkg::PRIME4;
                    idx_next = idx_reg + 2'd1;
                end
            end
            xxh_pkg::ST_ADDLEN:
            begin
                h_next    = h_reg + total_reg;
                idx_next  = 2'd0;
                mode_next = xxh_pkg::MODE_FOLD;
            end
            xxh_pkg::ST_FOLD_CHK:
            begin
                k_next = rem_reg[2] ? 3'd4 : 3'd0;
            end
            xxh_pkg::ST_FOLD_H:
            begin
                if (done)
                begin
                    h_next = mul_rsp.p + xxh_pkg::PRIME4;
                    if (idx_reg < wp_reg)
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                    else
                    begin
                        tail_next = 1'b0;
                    end
                end
            end
            xxh_pkg::ST_CHUNK_A,
            xxh_pkg::ST_BYTE_A:
            begin
                if (done)
                begin
                    h_next = h_reg ^ mul_rsp.p;
                end
            end
            xxh_pkg::ST_CHUNK_B:
            begin
                if (done)
                begin
                    h_next = mul_rsp.p + xxh_pkg::PRIME3;
                end
            end
            xxh_pkg::ST_BYTE_B:
            begin
                if (done)
                begin
                    h_next = mul_rsp.p;
                    k_next = k_reg + 3'd1;
                end
            end
            xxh_pkg::ST_AV1,
            xxh_pkg::ST_AV2:
            begin
                if (done)
                begin
                    h_next = mul_rsp.p;
                end
            end
            xxh_pkg::ST_EMIT:
            begin
                if (res_free)
                begin
                    acc_next[0] = seed_reg + xxh_pkg::LANE0_OFS;
                    acc_next[1] = seed_reg + xxh_pkg::PRIME2;
                    acc_next[2] = seed_reg;
                    acc_next[3] = seed_reg + xxh_pkg::LANE3_OFS;
                    wp_next     = 2'd0;
                    total_next  = 64'd0;
                end
            end
            default:
            begin
                h_next = h_reg;
            end
        endcase

        // A seed write starts a new message from the new seed
        if (cfg_we)
        begin
            seed_next   = cfg_wdata;
            acc_next[0] = cfg_wdata + xxh_pkg::LANE0_OFS;
            acc_next[1] = cfg_wdata + xxh_pkg::PRIME2;
            acc_next[2] = cfg_wdata;
            acc_next[3] = cfg_wdata + xxh_pkg::LANE3_OFS;
            wp_next     = 2'd0;
            total_next  = 64'd0;
        end
    end

    // Control and lane state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= xxh_pkg::ST_IDLE;
            mode_reg   <= xxh_pkg::MODE_STRIPE;
            idx_reg    <= 2'd0;
            wp_reg     <= 2'd0;
            k_reg      <= 3'd0;
            rem_reg    <= 3'd0;
            fin_reg    <= 1'b0;
            tail_reg   <= 1'b0;
            total_reg  <= 64'd0;
            seed_reg   <= 64'd0;
            acc_reg[0] <= xxh_pkg::LANE0_OFS;
            acc_reg[1] <= xxh_pkg::PRIME2;
            acc_reg[2] <= 64'd0;
            acc_reg[3] <= xxh_pkg::LANE3_OFS;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            idx_reg    <= idx_next;
            wp_reg     <= wp_next;
            k_reg      <= k_next;
            rem_reg    <= rem_next;
            fin_reg    <= fin_next;
            tail_reg   <= tail_next;
            total_reg  <= total_next;
            seed_reg   <= seed_next;
            acc_reg    <= acc_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        cnt_reg  <= cnt_next;
        h_reg    <= h_next;
        t_reg    <= t_next;
        if (stripe_we)
        begin
            stripe_reg[wp_reg] <= word_reg;
        end
    end

endmodule

### hw/rtl/xxhash64_stream_hash.sv
// ----------------------------------------------------------------------------
// XXH64 stream hash, top level
// Every 64-bit multiply runs on the one shared 32x32 multiplier, and the last
// word also waits on any output stall. Reset clears the seed to 0 and loads
// the lanes.
// ----------------------------------------------------------------------------
module xxhash64_stream_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // data_word[63:0], byte_count[67:64], zero pad
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // digest[63:0]
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata
);

    xxh_pkg::res_t res;
    logic          res_free;
    logic          m_tvalid_reg;
    logic          m_tvalid_next;
    logic [63:0]   digest_reg;

    xxh_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_word   (s_axis_tdata[63:0]),
        .in_count  (s_axis_tdata[67:64]),
        .in_last   (s_axis_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .res_free  (res_free),
        .res       (res)
    );

    // Output register: a new digest may load as the old word leaves
    always_comb
    begin
        res_free = !m_tvalid_reg || m_axis_tready;
        if (res.valid)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            digest_reg <= res.digest;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = digest_reg;

`ifndef NO_ASSERTIONS
    // A digest never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (!m_tvalid_reg || m_axis_tready))
        else $error("digest overwrote a pending output word");

    // The engine is busy while it hands over a digest
    a_emit_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !s_axis_tready)
        else $error("input ready while a digest is produced");

    // A last word always keeps the engine busy in the next cycle
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input ready right after a last word");
`endif

endmodule

### tb/tb_xxhash64_stream_hash.sv
// ----------------------------------------------------------------------------
// XXH64 stream hash testbench
// Feeds message words over the input stream and checks every digest against
// a cycle-free model of XXH64 kept in the bench (or a typed digest). Directed
// words from a short table come first, then random messages under four idling
// patterns with a new seed per pattern, one seed change landing mid-message.
// ----------------------------------------------------------------------------
module tb_xxhash64_stream_hash;

    // XXH64 primes
    localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] P3 = 64'h165667B19E3779F9;
    localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] EMPTY_HASH  = 64'hEF46DB3751D8E999;
    localparam int          DRAIN_CYCLES = 250;
    localparam int          PHASE_WORDS  = 370;
    localparam int          ROW_CNT      = 23;

    // One directed word; the digest is used only where typed is set
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        fin;
        logic        typed;
        logic [63:0] digest;
    } stim_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // data_word[63:0], byte_count[67:64], zero pad
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // digest[63:0]
    logic        cfg_we = 1'b0;
    logic [63:0] cfg_wdata = '0;

    // Bench copy of the hash state
    logic [63:0] cur_seed;
    logic [63:0] lane_v [4];
    logic [63:0] pend_w [3];
    int unsigned pend_n;
    logic [63:0] msg_len;

    logic [63:0] digest_q [$];
    logic [63:0] exp_dig;
    int          err_cnt = 0;
    int          items_sent = 0;
    int          send_idle = 0;
    int          recv_stall = 0;

    // Directed words: short messages at the byte-count corners, then longer ones
    stim_row_t dir_tab [ROW_CNT] = '{
        '{64'h0,                  4'd0,  1'b1, 1'b1, EMPTY_HASH},
        '{ALL_ONES,               4'd1,  1'b1, 1'b0, 64'h0},
        '{64'h0000_0000_0063_6261, 4'd3, 1'b1, 1'b0, 64'h0},
        '{ALL_ONES,               4'd4,  1'b1, 1'b0, 64'h0},
        '{ALL_ONES,               4'd7,  1'b1, 1'b0, 64'h0},
        '{64'h0,                  4'd8,  1'b1, 1'b0, 64'h0},
        '{ALL_ONES,               4'd15, 1'b1, 1'b0, 64'h0},
        '{64'h0123_4567_89AB_CDEF, 4'd9, 1'b1, 1'b0, 64'h0},
        '{ALL_ONES,               4'd8,  1'b0, 1'b0, 64'h0},
        '{ALL_ONES,               4'd0,  1'b1, 1'b0, 64'h0},
        '{64'h0123_4567_89AB_CDEF, 4'd2, 1'b0, 1'b0, 64'h0},
        '{64'hFEDC_BA98_7654_3210, 4'd0, 1'b0, 1'b0, 64'h0},
        '{ALL_ONES,               4'd5,  1'b1, 1'b0, 64'h0},
        '{64'h0,                  4'd8,  1'b0, 1'b0, 64'h0},
        '{ALL_ONES,               4'd8,  1'b0, 1'b0, 64'h0},
        '{64'h5555_5555_5555_5555, 4'd8, 1'b0, 1'b0, 64'h0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 4'd8, 1'b1, 1'b0, 64'h0},
        '{ALL_ONES,               4'd8,  1'b0, 1'b0, 64'h0},
        '{ALL_ONES,               4'd8,  1'b0, 1'b0, 64'h0},
        '{64'h0,                  4'd8,  1'b0, 1'b0, 64'h0},
        '{64'h0,                  4'd8,  1'b0, 1'b0, 64'h0},
        '{64'h8000_0000_0000_0001, 4'd8, 1'b0, 1'b0, 64'h0},
        '{64'hDEAD_BEEF_CAFE_F00D, 4'd4, 1'b1, 1'b0, 64'h0}
    };

    xxhash64_stream_hash dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    // Multiply-rotate-multiply round of one lane
    function automatic logic [63:0] xxh_round(input logic [63:0] acc, input logic [63:0] w);
        logic [63:0] a;
        a = acc + w * P2;
        a = rotl64(a, 31);
        return a * P1;
    endfunction

    function automatic logic [63:0] xxh_merge(input logic [63:0] h, input logic [63:0] lane);
        logic [63:0] t;
        t = h ^ xxh_round(64'h0, lane);
        return t * P1 + P4;
    endfunction

    function automatic logic [63:0] xxh_fold(input logic [63:0] h, input logic [63:0] w);
        logic [63:0] t;
        t = h ^ xxh_round(64'h0, w);
        return rotl64(t, 27) * P1 + P4;
    endfunction

    // Start a new message from the current seed
    function automatic void reload_lanes();
        lane_v[0] = cur_seed + P1 + P2;
        lane_v[1] = cur_seed + P2;
        lane_v[2] = cur_seed;
        lane_v[3] = cur_seed - P1;
        pend_n    = 0;
        msg_len   = '0;
    endfunction

    // Buffer a word, or run all four lanes once a stripe is complete
    function automatic void absorb_word(input logic [63:0] w);
        if (pend_n < 3)
        begin
            pend_w[pend_n] = w;
            pend_n++;
        end
        else
        begin
            lane_v[0] = xxh_round(lane_v[0], pend_w[0]);
            lane_v[1] = xxh_round(lane_v[1], pend_w[1]);
            lane_v[2] = xxh_round(lane_v[2], pend_w[2]);
            lane_v[3] = xxh_round(lane_v[3], w);
            pend_n    = 0;
        end
    endfunction

    // Take one accepted word; returns 1 with the digest when the message closes
    function automatic bit hash_word(input logic [63:0] w, input logic [3:0] cnt,
                                     input logic fin, output logic [63:0] dig);
        int unsigned n;
        int unsigned rem;
        int unsigned k;
        bit          tail;
        logic [63:0] h;
        dig = '0;
        if (!fin)
        begin
            // A word before the last one always counts as eight bytes.
            absorb_word(w);
            msg_len += 64'd8;
            return 1'b0;
        end

        n = (cnt > 4'd8) ? 8 : cnt;
        msg_len += 64'(n);
        rem  = n;
        tail = 1'b0;
        if (n == 8)
        begin
            if (pend_n == 3)
                absorb_word(w);
            else
                tail = 1'b1;
            rem = 0;
        end

        // Lanes are merged only once a full stripe's worth of bytes came in.
        if (msg_len >= 64'd32)
        begin
            h = rotl64(lane_v[0], 1) + rotl64(lane_v[1], 7) +
                rotl64(lane_v[2], 12) + rotl64(lane_v[3], 18);
            for (int i = 0; i < 4; i++)
                h = xxh_merge(h, lane_v[i]);
        end
        else
            h = cur_seed + P5;
        h += msg_len;

        for (int i = 0; i < pend_n; i++)
            h = xxh_fold(h, pend_w[i]);
        if (tail)
            h = xxh_fold(h, w);

        // Fold the 4-byte chunk, then the single bytes
        k = 0;
        if (rem >= 4)
        begin
            h ^= {32'h0, w[31:0]} * P1;
            h  = rotl64(h, 23) * P2 + P3;
            k  = 4;
        end
        while (k < rem)
        begin
            h ^= {56'h0, w[8*k +: 8]} * P5;
            h  = rotl64(h, 11) * P1;
            k++;
        end

        // Avalanche
        h ^= h >> 33;
        h *= P2;
        h ^= h >> 29;
        h *= P3;
        h ^= h >> 32;

        dig = h;
        reload_lanes();
        return 1'b1;
    endfunction

    function automatic logic [63:0] rand_data();
        case ($urandom_range(15))
            0:       return 64'h0;
            1:       return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Present one word, wait for its handshake and predict its digest
    task automatic send_word(input logic [63:0] w, input logic [3:0] cnt, input logic fin,
                             input bit typed, input logic [63:0] typed_dig);
        logic [63:0] dig;
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'h0, cnt, w};
        s_axis_tlast  = fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (hash_word(w, cnt, fin, dig))
            digest_q.push_back(typed ? typed_dig : dig);
        items_sent++;
    endtask

    // Stop sending and wait until every digest is out, optionally for the block too
    task automatic settle(input bit drain);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
        if (drain)
            repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] v);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
        cur_seed  = v;
        reload_lanes();
    endtask

    // Random message: mostly short, some spanning many stripes
    task automatic send_message();
        int          r;
        int          k;
        logic [3:0]  c;
        r = $urandom_range(99);
        if (r < 50)
            k = $urandom_range(4);
        else if (r < 85)
            k = $urandom_range(12, 5);
        else
            k = $urandom_range(40, 13);
        repeat (k)
        begin
            c = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'd8;
            send_word(rand_data(), c, 1'b0, 1'b0, 64'h0);
        end
        c = ($urandom_range(99) < 80) ? 4'($urandom_range(8)) : 4'($urandom_range(15, 9));
        send_word(rand_data(), c, 1'b1, 1'b0, 64'h0);
    endtask

    // Receiver back-pressure
    always @(negedge clk)
        m_axis_tready = ($urandom_range(99) >= recv_stall);

    // Compare each digest with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_q.size() == 0)
            begin
                $display("%0t unexpected digest: expected none, got %h", $time, m_axis_tdata);
                err_cnt++;
            end
            else
            begin
                exp_dig = digest_q.pop_front();
                if (m_axis_tdata !== exp_dig)
                begin
                    $display("%0t digest mismatch: expected %h, got %h",
                             $time, exp_dig, m_axis_tdata);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        int          target;
        logic [63:0] phase_seed;
        cur_seed = '0;
        reload_lanes();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words from reset with the default seed
        for (int i = 0; i < ROW_CNT; i++)
            send_word(dir_tab[i].data, dir_tab[i].cnt, dir_tab[i].fin,
                      dir_tab[i].typed, dir_tab[i].digest);
        settle(1'b1);

        // Random messages, one idling pattern and seed per phase
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle = 0;  recv_stall = 0;  phase_seed = ALL_ONES; end
                1:       begin send_idle = 77; recv_stall = 0;  phase_seed = {$urandom, $urandom}; end
                2:       begin send_idle = 0;  recv_stall = 77; phase_seed = 64'h0; end
                default: begin send_idle = 31; recv_stall = 31; phase_seed = P1; end
            endcase
            write_seed(phase_seed);
            target = items_sent + PHASE_WORDS;
            while (items_sent < target)
            begin
                send_message();
                if ($urandom_range(9) == 0)
                    settle(1'b0);
            end
            // Leave a message open so the next seed write restarts it.
            if (ph % 2 == 1)
                repeat ($urandom_range(6, 1))
                    send_word(rand_data(), 4'd8, 1'b0, 1'b0, 64'h0);
            settle(1'b1);
        end

        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
